/* rtl/core/risc16_instruction_step_defines.svh */
// Assertion macros for the RiSC-16 instruction step block.
`ifndef RISC16_INSTRUCTION_STEP_DEFINES_SVH
`define RISC16_INSTRUCTION_STEP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define R16_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("risc16 check failed");

// next-cycle implication, clocked on clk, off during rst
`define R16_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("risc16 check failed");

`endif

/* rtl/core/risc16_pkg.sv */
// Shared types, codes and helpers for the RiSC-16 instruction step block.
`timescale 1ns / 1ps
`default_nettype none

package risc16_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;
  localparam int REG_IDX_BITS      = 3;

  typedef logic [15:0]             word_t;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  typedef enum logic [1:0] {
    CMD_STEP      = 2'd0,
    CMD_MEM_WRITE = 2'd1,
    CMD_MEM_READ  = 2'd2,
    CMD_REG_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_ADDI = 3'd1,
    OP_NAND = 3'd2,
    OP_LUI  = 3'd3,
    OP_SW   = 3'd4,
    OP_LW   = 3'd5,
    OP_BEQ  = 3'd6,
    OP_JALR = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_LOAD,
    S_HOST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [15:0] word_data;
  } req_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] pc_after;
    logic        halted_flag;
  } rsp_word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic     en;
    reg_idx_t idx;
    word_t    data;
  } rf_wr_t;

  function automatic word_t sext7(word_t w);
    return {{9{w[6]}}, w[6:0]};
  endfunction

  function automatic word_t lui_value(word_t w);
    return {w[9:0], 6'b000000};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/risc16_instruction_step.sv */
// Top level of the RiSC-16 instruction step block: sequencer, PC and result register.
//
//   channel  dir  handshake              word
//   req      in   req_valid / req_ready  req_word_t (command, address, word_data)
//   rsp      out  rsp_valid / rsp_ready  rsp_word_t (read_data, pc_after, halted_flag)
//
// Step: accept/fetch read, decode + register read, execute, result (lw adds a load step
//   before the result); the single memory port serializes instruction fetch and data access.
// Memory write: accept, result; memory or register read: accept, host read, result.
// After rst a clearing pass writes zero to all 2**MEM_ADDR_BITS words, one per cycle,
//   with req_ready low.
// A finished word waits in the rsp register; the next word is taken meanwhile, and a
//   second result holds in the result state until the rsp register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "risc16_instruction_step_defines.svh"

module risc16_instruction_step #(
  parameter int MEM_ADDR_BITS = risc16_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  risc16_pkg::req_word_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output risc16_pkg::rsp_word_t rsp
);
  import risc16_pkg::*;

  localparam logic [MEM_ADDR_BITS-1:0] ClearLast = '1;

  state_t                   state;
  state_t                   state_next;
  word_t                    pc;
  word_t                    pc_next;
  word_t                    ir;
  cmd_t                     cmd;
  logic [MEM_ADDR_BITS-1:0] clear_addr;
  word_t                    res_data;
  word_t                    res_data_next;
  rsp_word_t                out_word;
  logic                     out_valid;

  logic                     accept;
  logic                     out_load;
  logic                     ir_load;

  mem_ctl_t                 mem_ctl;
  logic [MEM_ADDR_BITS-1:0] mem_addr;
  word_t                    mem_wdata;
  word_t                    mem_rdata;

  logic                     rf_rd_en;
  reg_idx_t                 rf_idx_a;
  reg_idx_t                 rf_idx_b;
  rf_wr_t                   rf_wr;
  word_t                    va;
  word_t                    vb;

  op_t                      f_op;
  op_t                      op;
  reg_idx_t                 ra;
  reg_idx_t                 rc;
  word_t                    pc_inc;
  word_t                    eff_addr;

  risc16_mem #(
    .ADDR_BITS(MEM_ADDR_BITS)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  risc16_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rf_rd_en),
    .rd_idx_a (rf_idx_a),
    .rd_idx_b (rf_idx_b),
    .wr       (rf_wr),
    .rd_data_a(va),
    .rd_data_b(vb)
  );

  assign req_ready = (state == S_IDLE) && !rst;
  assign accept    = req_valid && req_ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp_ready);

  assign f_op     = op_t'(mem_rdata[15:13]);
  assign op       = op_t'(ir[15:13]);
  assign ra       = ir[12:10];
  assign rc       = ir[2:0];
  assign pc_inc   = pc + 16'd1;
  assign eff_addr = vb + sext7(ir);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clear_addr == ClearLast) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(req.command))
            CMD_STEP:      state_next = S_FETCH;
            CMD_MEM_WRITE: state_next = S_DONE;
            default:       state_next = S_HOST;
          endcase
        end
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        state_next = (op == OP_LW) ? S_LOAD : S_DONE;
      end
      S_LOAD:  state_next = S_DONE;
      S_HOST:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    mem_ctl       = '0;
    mem_addr      = clear_addr;
    mem_wdata     = '0;
    rf_rd_en      = 1'b0;
    rf_idx_a      = req.address[REG_IDX_BITS-1:0];
    rf_idx_b      = mem_rdata[9:7];
    rf_wr         = '0;
    pc_next       = pc;
    res_data_next = res_data;
    ir_load       = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(req.command))
            CMD_STEP: begin
              mem_ctl.rd_en = 1'b1;
              mem_addr      = pc[MEM_ADDR_BITS-1:0];
            end
            CMD_MEM_WRITE: begin
              mem_ctl.wr_en = 1'b1;
              mem_addr      = req.address[MEM_ADDR_BITS-1:0];
              mem_wdata     = req.word_data;
              res_data_next = '0;
            end
            CMD_MEM_READ: begin
              mem_ctl.rd_en = 1'b1;
              mem_addr      = req.address[MEM_ADDR_BITS-1:0];
            end
            default: begin
              rf_rd_en = 1'b1;
            end
          endcase
        end
      end
      S_FETCH: begin
        ir_load  = 1'b1;
        rf_rd_en = 1'b1;
        rf_idx_a = (f_op == OP_NAND) ? mem_rdata[2:0] : mem_rdata[12:10];
      end
      S_EXEC: begin
        res_data_next = ir;
        pc_next       = pc_inc;
        case (op)
          OP_ADD:  rf_wr = '{en: 1'b1, idx: rc, data: word_t'(va + vb)};
          OP_ADDI: rf_wr = '{en: 1'b1, idx: ra, data: eff_addr};
          OP_NAND: rf_wr = '{en: 1'b1, idx: ra, data: ~(vb & va)};
          OP_LUI:  rf_wr = '{en: 1'b1, idx: ra, data: lui_value(ir)};
          OP_SW: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = eff_addr[MEM_ADDR_BITS-1:0];
            mem_wdata     = va;
          end
          OP_LW: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = eff_addr[MEM_ADDR_BITS-1:0];
          end
          OP_BEQ: begin
            if (va == vb) begin
              pc_next = pc_inc + sext7(ir);
            end
          end
          default: begin
            rf_wr   = '{en: 1'b1, idx: ra, data: pc_inc};
            pc_next = vb;
          end
        endcase
      end
      S_LOAD: begin
        rf_wr = '{en: 1'b1, idx: ra, data: mem_rdata};
      end
      S_HOST: begin
        res_data_next = (cmd == CMD_MEM_READ) ? mem_rdata : va;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pc         <= '0;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_t'(req.command);
    end
    if (ir_load) begin
      ir <= mem_rdata;
    end
    res_data <= res_data_next;
    if (out_load) begin
      out_word <= '{read_data: res_data, pc_after: pc, halted_flag: 1'b0};
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_word;

  `R16_ASSERT_NXT(a_accept_leaves_idle, accept, state != S_IDLE)
  `R16_ASSERT_NXT(a_host_keeps_pc, accept && (req.command != CMD_STEP), $stable(pc))
  `R16_ASSERT_IMP(a_load_after_exec, state == S_LOAD, $past(state) == S_EXEC)
  `R16_ASSERT_IMP(a_never_halted, rsp_valid, !rsp.halted_flag)

endmodule

`default_nettype wire

/* rtl/core/risc16_mem.sv */
// Single-port main memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module risc16_mem #(
  parameter int ADDR_BITS = risc16_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  risc16_pkg::mem_ctl_t ctl,
  input  logic [ADDR_BITS-1:0] addr,
  input  risc16_pkg::word_t    wdata,
  output risc16_pkg::word_t    rdata
);
  import risc16_pkg::*;

  localparam int Depth = 2 ** ADDR_BITS;

  word_t mem [Depth];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/risc16_regs.sv */
// Eight-entry register file, two registered read ports, valid bits for reset.
`timescale 1ns / 1ps
`default_nettype none

module risc16_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  risc16_pkg::reg_idx_t rd_idx_a,
  input  risc16_pkg::reg_idx_t rd_idx_b,
  input  risc16_pkg::rf_wr_t   wr,
  output risc16_pkg::word_t    rd_data_a,
  output risc16_pkg::word_t    rd_data_b
);
  import risc16_pkg::*;

  localparam int Depth = 2 ** REG_IDX_BITS;

  word_t            regs [Depth];
  logic [Depth-1:0] valid;
  word_t            q_a;
  word_t            q_b;
  logic             ok_a;
  logic             ok_b;
  logic             wr_take;

  // drop writes to register zero
  assign wr_take = wr.en && (wr.idx != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_take) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_take) begin
      regs[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a <= regs[rd_idx_a];
      q_b <= regs[rd_idx_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok_a <= 1'b0;
      ok_b <= 1'b0;
    end else if (rd_en) begin
      ok_a <= valid[rd_idx_a];
      ok_b <= valid[rd_idx_b];
    end
  end

  assign rd_data_a = ok_a ? q_a : '0;
  assign rd_data_b = ok_b ? q_b : '0;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the RiSC-16 instruction step block.
`timescale 1ns / 1ps

module testbench;
  import risc16_pkg::*;

  localparam int MEM_BITS    = MEM_ADDR_BITS_DEF;
  localparam int ITEM_TARGET = 1100;
  localparam int STALL_LIMIT = 300000;
  localparam int TAIL_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  risc16_instruction_step dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  word_t      core_pc = '0;
  bit [15:0]  core_regs [0:7];
  bit [15:0]  core_mem [0:(1 << MEM_BITS) - 1];
  word_t      last_store = '0;

  rsp_word_t  expected_rsp [$];
  rsp_word_t  due;
  int         items_sent = 0;
  int         steps_sent = 0;
  int         writes_sent = 0;
  int         reads_sent = 0;
  int         rsp_checked = 0;
  int         fail_count = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  int         ready_cycle = 0;
  int         ready_mode = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic word_t offset7(word_t ir);
    return word_t'($signed(ir[6:0]));
  endfunction

  function automatic word_t reg_value(logic [2:0] idx);
    return (idx == 3'd0) ? 16'd0 : core_regs[idx];
  endfunction

  function automatic void reg_store(logic [2:0] idx, word_t v);
    if (idx != 3'd0) begin
      core_regs[idx] = v;
    end
  endfunction

  function automatic word_t encode(op_t op, logic [2:0] ra, logic [9:0] rest);
    return {op, ra, rest};
  endfunction

  function automatic req_word_t host_word(cmd_t c, word_t a, word_t d);
    req_word_t w;
    w.command   = c;
    w.address   = a;
    w.word_data = d;
    return w;
  endfunction

  task automatic model_item(input req_word_t w, output rsp_word_t r);
    word_t      ir, nxt, vb, ea;
    logic [2:0] ra, rb, rc;
    r = '0;
    case (cmd_t'(w.command))
      CMD_STEP: begin
        ir  = core_mem[core_pc[MEM_BITS-1:0]];
        ra  = ir[12:10];
        rb  = ir[9:7];
        rc  = ir[2:0];
        vb  = reg_value(rb);
        ea  = vb + offset7(ir);
        nxt = core_pc + 16'd1;
        case (op_t'(ir[15:13]))
          OP_ADD:  reg_store(rc, reg_value(ra) + vb);
          OP_ADDI: reg_store(ra, ea);
          OP_NAND: reg_store(ra, ~(vb & reg_value(rc)));
          OP_LUI:  reg_store(ra, {ir[9:0], 6'd0});
          OP_SW: begin
            core_mem[ea[MEM_BITS-1:0]] = reg_value(ra);
            last_store = ea;
          end
          OP_LW:   reg_store(ra, core_mem[ea[MEM_BITS-1:0]]);
          OP_BEQ: begin
            if (reg_value(ra) == vb) begin
              nxt = nxt + offset7(ir);
            end
          end
          default: begin
            reg_store(ra, nxt);
            nxt = vb;
          end
        endcase
        core_pc = nxt;
        r.read_data = ir;
      end
      CMD_MEM_WRITE: core_mem[w.address[MEM_BITS-1:0]] = w.word_data;
      CMD_MEM_READ:  r.read_data = core_mem[w.address[MEM_BITS-1:0]];
      default:       r.read_data = reg_value(w.address[2:0]);
    endcase
    r.pc_after    = core_pc;
    r.halted_flag = 1'b0;
  endtask

  task automatic send_word(input req_word_t w);
    rsp_word_t r;
    int        gap;
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_ready !== 1'b1);
    model_item(w, r);
    expected_rsp.push_back(r);
    items_sent++;
    case (cmd_t'(w.command))
      CMD_STEP:      steps_sent++;
      CMD_MEM_WRITE: writes_sent++;
      default:       reads_sent++;
    endcase
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic step_core();
    send_word(host_word(CMD_STEP, word_t'($urandom_range(0, 65535)),
                        word_t'($urandom_range(0, 65535))));
  endtask

  function automatic word_t rand_instr();
    op_t        op;
    logic [2:0] ra, rb;
    logic [6:0] imm;
    if ($urandom_range(0, 3) == 0) begin
      return word_t'($urandom_range(0, 65535));
    end
    op  = op_t'($urandom_range(0, 7));
    ra  = 3'($urandom_range(0, 7));
    rb  = 3'($urandom_range(0, 7));
    imm = 7'($urandom_range(0, 127));
    if (op == OP_BEQ && $urandom_range(0, 1) == 1) begin
      rb = ra;
    end
    if (op == OP_LUI) begin
      return encode(op, ra, 10'($urandom_range(0, 1023)));
    end
    return encode(op, ra, {rb, imm});
  endfunction

  task automatic test_reset_state();
    send_word(host_word(CMD_REG_READ, 16'h0003, 16'h0000));
  endtask

  task automatic test_host_extremes();
    send_word(host_word(CMD_MEM_WRITE, 16'hFFFF, 16'hFFFF));
    send_word(host_word(CMD_MEM_WRITE, 16'hFF80, 16'hA5A5));
    send_word(host_word(CMD_MEM_READ, 16'hFFFF, 16'h0000));
    send_word(host_word(CMD_REG_READ, 16'hFFFF, 16'hFFFF));
    send_word(host_word(CMD_REG_READ, 16'hFFF8, 16'h0000));
  endtask

  task automatic test_directed_program();
    word_t prog [8];
    prog[0] = encode(OP_LUI,  3'd1, 10'h3FF);
    prog[1] = encode(OP_ADDI, 3'd2, {3'd1, 7'h3F});
    prog[2] = encode(OP_ADD,  3'd2, {3'd1, 4'd0, 3'd0});
    prog[3] = encode(OP_ADD,  3'd2, {3'd1, 4'd0, 3'd3});
    prog[4] = encode(OP_NAND, 3'd4, {3'd2, 4'd0, 3'd3});
    prog[5] = encode(OP_SW,   3'd2, {3'd2, 7'h01});
    prog[6] = encode(OP_LW,   3'd5, {3'd1, 7'h40});
    prog[7] = encode(OP_BEQ,  3'd0, {3'd0, 7'h78});
    for (int k = 0; k < 8; k++) begin
      send_word(host_word(CMD_MEM_WRITE, word_t'(k), prog[k]));
    end
    // sw wrapped onto word 0, so the branch back lands on a jalr r7, r7
    for (int k = 0; k < 10; k++) begin
      step_core();
    end
    send_word(host_word(CMD_MEM_READ, 16'h0000, 16'h0000));
  endtask

  task automatic test_random_programs();
    word_t base;
    int    len;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        base = core_pc;
        len  = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_word(host_word(CMD_MEM_WRITE, base + word_t'(k), rand_instr()));
        end
        for (int k = 0; k < len; k++) begin
          step_core();
          if ($urandom_range(0, 5) == 0) begin
            send_word(host_word(CMD_REG_READ, word_t'($urandom_range(0, 65535)),
                                word_t'($urandom_range(0, 65535))));
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          send_word(host_word(CMD_MEM_READ, last_store, word_t'($urandom_range(0, 65535))));
        end
      end else begin
        case ($urandom_range(0, 3))
          0: send_word(host_word(CMD_MEM_WRITE, word_t'($urandom_range(0, 65535)),
                                 word_t'($urandom_range(0, 65535))));
          1: send_word(host_word(CMD_MEM_READ, word_t'($urandom_range(0, 65535)),
                                 word_t'($urandom_range(0, 65535))));
          2: send_word(host_word(CMD_REG_READ, word_t'($urandom_range(0, 65535)),
                                 word_t'($urandom_range(0, 65535))));
          default: step_core();
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    ready_cycle++;
    if (ready_cycle % 256 == 0) begin
      ready_mode = $urandom_range(0, 2);
    end
    case (ready_mode)
      0:       rsp_ready <= 1'b1;
      1:       rsp_ready <= 1'($urandom_range(0, 1));
      default: rsp_ready <= (ready_cycle % 16) < 10;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
        fail_count++;
      end else begin
        due = expected_rsp.pop_front();
        rsp_checked++;
        if (rsp.read_data !== due.read_data) begin
          $display("%0t: read_data mismatch, expected %h, actual %h",
                   $time, due.read_data, rsp.read_data);
          fail_count++;
        end
        if (rsp.pc_after !== due.pc_after) begin
          $display("%0t: pc_after mismatch, expected %h, actual %h",
                   $time, due.pc_after, rsp.pc_after);
          fail_count++;
        end
        if (rsp.halted_flag !== due.halted_flag) begin
          $display("%0t: halted_flag mismatch, expected %b, actual %b",
                   $time, due.halted_flag, rsp.halted_flag);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_host_extremes();
    test_directed_program();
    test_random_programs();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d words: %0d steps, %0d memory writes, %0d reads", items_sent,
             steps_sent, writes_sent, reads_sent);
    $display("Checked %0d responses, %0d mismatches", rsp_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* risc16_instruction_step.f */
+incdir+rtl/core
rtl/core/risc16_pkg.sv
rtl/core/risc16_mem.sv
rtl/core/risc16_regs.sv
rtl/core/risc16_instruction_step.sv
bench/testbench.sv
